FILE: rtl/lz77bp_pkg.sv
// Package for the byte-pair LZ77 decompressor: payload structs, state and
// operation codes, status codes and sizing constants.
// Used by every module of the block; depends on nothing.
package lz77bp_pkg;

    localparam int HIST_DEPTH = 2048;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam logic [12:0] LIMIT_RESET = 13'd6000;
    localparam logic [7:0]  SPACE_CHAR  = 8'h20;
    localparam logic [7:0]  XOR_MASK    = 8'h80;
    localparam logic [7:0]  PAIR_BASE   = 8'd128;
    localparam logic [7:0]  SPACE_BASE  = 8'd192;
    localparam logic [7:0]  LIT_MAX     = 8'd8;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_BAD_DIST = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       rec_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        run_last;
        logic        record_done;
        logic [1:0]  status;
        logic [12:0] record_length;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CHK_ROOM,
        S_COPY_RD,
        S_EMIT,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        K_LIT_CMD,
        K_SINGLE,
        K_SPACE,
        K_COPY
    } kind_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic [13:0] a;
        logic [13:0] b;
        logic [13:0] c;
    } alu_req_t;

    typedef struct packed {
        logic [13:0] res;
        logic        flag;
    } alu_rsp_t;

endpackage

FILE: rtl/lz77bp_alu.sv
// Shared add/subtract and compare unit of the decompressor sequencer.
// Depends on lz77bp_pkg for the request and response structs.
module lz77bp_alu (
    input  lz77bp_pkg::alu_req_t req,
    output lz77bp_pkg::alu_rsp_t rsp
);

    logic [14:0] diff;
    logic [13:0] sum;

    assign sum  = req.a + req.b;
    assign diff = {1'b0, req.a} - {1'b0, req.b};

    // Add reports a sum above the bound; subtract reports a borrow.
    always_comb
    begin
        unique case (req.op)
            lz77bp_pkg::ALU_ADD:
            begin
                rsp.res  = sum;
                rsp.flag = (sum > req.c);
            end
            lz77bp_pkg::ALU_SUB:
            begin
                rsp.res  = diff[13:0];
                rsp.flag = diff[14];
            end
            default:
            begin
                rsp.res  = sum;
                rsp.flag = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/lz77bp_hist.sv
// History memory of decompressed bytes: one write port, one registered read.
// Depends on lz77bp_pkg for the depth and address width.
module lz77bp_hist (
    input  logic                           clk,
    input  logic                           we,
    input  logic [lz77bp_pkg::HIST_AW-1:0] waddr,
    input  logic [7:0]                     wdata,
    input  logic                           re,
    input  logic [lz77bp_pkg::HIST_AW-1:0] raddr,
    output logic [7:0]                     rdata
);

    logic [7:0] mem [lz77bp_pkg::HIST_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lz77_byte_pair_decompressor_top.sv
// Top level of the byte-pair LZ77 decompressor: sequencer, record state and
// output register. Depends on lz77bp_pkg, lz77bp_alu and lz77bp_hist.
//
//  channel | signals                       | transfer when
//  --------+-------------------------------+---------------------------
//  in      | in_valid, in_stall, in_data   | in_valid  && !in_stall
//  out     | out_valid, out_stall, out_data| out_valid && !out_stall
//  cfg     | cfg_we, cfg_wdata             | cfg_we
//
// One compressed byte at a time: every byte passes the idle and decode steps;
// one with no output ends in the finish step, others in emit steps that give
// their output bytes, and every copied byte needs a history read before its emit.
// The shared adder does the room, distance and source address work in turn.
// Reset clears the record state but not the history. A stalled output holds
// the sequencer in its emit or finish step until the waiting result moves on.
module lz77_byte_pair_decompressor_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lz77bp_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output lz77bp_pkg::out_item_t out_data,
    input  logic                  cfg_we,
    input  logic [12:0]           cfg_wdata
);

    lz77bp_pkg::state_t    state_reg, state_next;
    lz77bp_pkg::kind_t     kind_reg, kind_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic [12:0]           produced_reg, produced_next;
    logic [3:0]            lit_pend_reg, lit_pend_next;
    logic [5:0]            pair_high_reg, pair_high_next;
    logic                  pair_pend_reg, pair_pend_next;
    logic [1:0]            sticky_reg, sticky_next;
    logic [12:0]           limit_reg, limit_next;
    logic [10:0]           dist_reg, dist_next;
    logic [3:0]            cnt_reg, cnt_next;
    logic [7:0]            emit_byte_reg, emit_byte_next;
    logic                  out_valid_reg, out_valid_next;
    lz77bp_pkg::out_item_t out_data_reg, out_data_next;

    lz77bp_pkg::alu_req_t  alu_req;
    lz77bp_pkg::alu_rsp_t  alu_rsp;

    logic [13:0] pair_word;
    logic [10:0] pair_dist;
    logic [3:0]  copy_len;
    logic        slot_free;
    logic        item_end;
    logic [7:0]  emit_src;
    logic [12:0] produced_inc;
    logic [1:0]  fin_status;
    logic        hist_we;
    logic        hist_re;
    logic [7:0]  hist_rdata;

    assign pair_word    = {pair_high_reg, byte_reg};
    assign pair_dist    = pair_word[13:3];
    assign copy_len     = {1'b0, pair_word[2:0]} + 4'd3;
    assign slot_free    = !out_valid_reg || !out_stall;
    assign item_end     = (cnt_reg == 4'd1);
    assign emit_src     = (kind_reg == lz77bp_pkg::K_COPY) ? hist_rdata : emit_byte_reg;
    assign produced_inc = produced_reg + 13'd1;
    // A record that closes with literals or a pair byte still owed is truncated, unless it already holds an error.
    assign fin_status   = ((sticky_reg == lz77bp_pkg::ST_OK)
                          && ((lit_pend_reg != 4'd0) || pair_pend_reg))
                          ? lz77bp_pkg::ST_TRUNC : sticky_reg;

    assign hist_we = (state_reg == lz77bp_pkg::S_EMIT) && slot_free;
    assign hist_re = (state_reg == lz77bp_pkg::S_COPY_RD);

    lz77bp_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    lz77bp_hist u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (produced_reg[lz77bp_pkg::HIST_AW-1:0]),
        .wdata (emit_src),
        .re    (hist_re),
        .raddr (alu_rsp.res[lz77bp_pkg::HIST_AW-1:0]),
        .rdata (hist_rdata)
    );

    // Operands for the shared unit in each step.
    always_comb
    begin
        alu_req.op = lz77bp_pkg::ALU_ADD;
        alu_req.a  = {1'b0, produced_reg};
        alu_req.b  = 14'd0;
        alu_req.c  = {1'b0, limit_reg};
        unique case (state_reg)
            lz77bp_pkg::S_DECODE:
            begin
                alu_req.op = lz77bp_pkg::ALU_SUB;
                alu_req.b  = {3'd0, pair_dist};
            end
            lz77bp_pkg::S_CHK_ROOM:
            begin
                alu_req.op = lz77bp_pkg::ALU_ADD;
                alu_req.b  = {10'd0, cnt_reg};
            end
            lz77bp_pkg::S_COPY_RD:
            begin
                alu_req.op = lz77bp_pkg::ALU_SUB;
                alu_req.b  = {3'd0, dist_reg};
            end
            default:
            begin
                alu_req.op = lz77bp_pkg::ALU_ADD;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lz77bp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lz77bp_pkg::S_DECODE;
                end
            end
            lz77bp_pkg::S_DECODE:
            begin
                priority if (lit_pend_reg != 4'd0)
                begin
                    state_next = (sticky_reg == lz77bp_pkg::ST_OK)
                                 ? lz77bp_pkg::S_EMIT : lz77bp_pkg::S_FINISH;
                end
                else if (pair_pend_reg)
                begin
                    state_next = ((sticky_reg != lz77bp_pkg::ST_OK) || (pair_dist == 11'd0)
                                 || alu_rsp.flag)
                                 ? lz77bp_pkg::S_FINISH : lz77bp_pkg::S_CHK_ROOM;
                end
                else if ((byte_reg >= lz77bp_pkg::PAIR_BASE)
                         && (byte_reg < lz77bp_pkg::SPACE_BASE))
                begin
                    state_next = lz77bp_pkg::S_FINISH;
                end
                else
                begin
                    state_next = lz77bp_pkg::S_CHK_ROOM;
                end
            end
            lz77bp_pkg::S_CHK_ROOM:
            begin
                priority if ((sticky_reg != lz77bp_pkg::ST_OK) || alu_rsp.flag
                             || (kind_reg == lz77bp_pkg::K_LIT_CMD))
                begin
                    state_next = lz77bp_pkg::S_FINISH;
                end
                else if (kind_reg == lz77bp_pkg::K_COPY)
                begin
                    state_next = lz77bp_pkg::S_COPY_RD;
                end
                else
                begin
                    state_next = lz77bp_pkg::S_EMIT;
                end
            end
            lz77bp_pkg::S_COPY_RD:
            begin
                state_next = lz77bp_pkg::S_EMIT;
            end
            lz77bp_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    priority if (item_end)
                    begin
                        state_next = lz77bp_pkg::S_IDLE;
                    end
                    else if (kind_reg == lz77bp_pkg::K_COPY)
                    begin
                        state_next = lz77bp_pkg::S_COPY_RD;
                    end
                    else
                    begin
                        state_next = lz77bp_pkg::S_EMIT;
                    end
                end
            end
            lz77bp_pkg::S_FINISH:
            begin
                if (!last_reg || slot_free)
                begin
                    state_next = lz77bp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lz77bp_pkg::S_IDLE;
            end
        endcase
    end

    // Record state, output register and configuration.
    always_comb
    begin
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        produced_next  = produced_reg;
        lit_pend_next  = lit_pend_reg;
        pair_high_next = pair_high_reg;
        pair_pend_next = pair_pend_reg;
        sticky_next    = sticky_reg;
        dist_next      = dist_reg;
        cnt_next       = cnt_reg;
        emit_byte_next = emit_byte_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        limit_next     = cfg_we ? cfg_wdata : limit_reg;

        unique case (state_reg)
            lz77bp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = in_data.in_byte;
                    last_next = in_data.rec_last;
                end
            end
            lz77bp_pkg::S_DECODE:
            begin
                priority if (lit_pend_reg != 4'd0)
                begin
                    lit_pend_next  = lit_pend_reg - 4'd1;
                    kind_next      = lz77bp_pkg::K_SINGLE;
                    emit_byte_next = byte_reg;
                    cnt_next       = 4'd1;
                end
                else if (pair_pend_reg)
                begin
                    pair_pend_next = 1'b0;
                    pair_high_next = 6'd0;
                    kind_next      = lz77bp_pkg::K_COPY;
                    dist_next      = pair_dist;
                    cnt_next       = copy_len;
                    if ((sticky_reg == lz77bp_pkg::ST_OK)
                        && ((pair_dist == 11'd0) || alu_rsp.flag))
                    begin
                        sticky_next = lz77bp_pkg::ST_BAD_DIST;
                    end
                end
                else if ((byte_reg != 8'd0) && (byte_reg <= lz77bp_pkg::LIT_MAX))
                begin
                    kind_next     = lz77bp_pkg::K_LIT_CMD;
                    lit_pend_next = byte_reg[3:0];
                    cnt_next      = byte_reg[3:0];
                end
                else if (byte_reg < lz77bp_pkg::PAIR_BASE)
                begin
                    kind_next      = lz77bp_pkg::K_SINGLE;
                    emit_byte_next = byte_reg;
                    cnt_next       = 4'd1;
                end
                else if (byte_reg >= lz77bp_pkg::SPACE_BASE)
                begin
                    kind_next      = lz77bp_pkg::K_SPACE;
                    emit_byte_next = lz77bp_pkg::SPACE_CHAR;
                    cnt_next       = 4'd2;
                end
                else
                begin
                    pair_high_next = byte_reg[5:0];
                    pair_pend_next = 1'b1;
                end
            end
            lz77bp_pkg::S_CHK_ROOM:
            begin
                if ((sticky_reg == lz77bp_pkg::ST_OK) && alu_rsp.flag)
                begin
                    sticky_next = lz77bp_pkg::ST_OVERFLOW;
                end
            end
            lz77bp_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.out_byte     = emit_src;
                    out_data_next.byte_valid   = 1'b1;
                    out_data_next.run_last     = item_end;
                    out_data_next.record_done  = item_end && last_reg;
                    out_data_next.status       = (item_end && last_reg) ? fin_status
                                                                       : sticky_reg;
                    out_data_next.record_length = produced_inc;
                    produced_next  = produced_inc;
                    cnt_next       = cnt_reg - 4'd1;
                    emit_byte_next = byte_reg ^ lz77bp_pkg::XOR_MASK;
                    if (item_end && last_reg)
                    begin
                        produced_next  = 13'd0;
                        lit_pend_next  = 4'd0;
                        pair_high_next = 6'd0;
                        pair_pend_next = 1'b0;
                        sticky_next    = lz77bp_pkg::ST_OK;
                    end
                end
            end
            lz77bp_pkg::S_FINISH:
            begin
                // The item gave no data; a closing byte still reports the record.
                if (last_reg && slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.out_byte      = 8'd0;
                    out_data_next.byte_valid    = 1'b0;
                    out_data_next.run_last      = 1'b1;
                    out_data_next.record_done   = 1'b1;
                    out_data_next.status        = fin_status;
                    out_data_next.record_length = produced_reg;
                    produced_next  = 13'd0;
                    lit_pend_next  = 4'd0;
                    pair_high_next = 6'd0;
                    pair_pend_next = 1'b0;
                    sticky_next    = lz77bp_pkg::ST_OK;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lz77bp_pkg::S_IDLE;
            produced_reg  <= 13'd0;
            lit_pend_reg  <= 4'd0;
            pair_high_reg <= 6'd0;
            pair_pend_reg <= 1'b0;
            sticky_reg    <= lz77bp_pkg::ST_OK;
            limit_reg     <= lz77bp_pkg::LIMIT_RESET;
            cnt_reg       <= 4'd0;
            kind_reg      <= lz77bp_pkg::K_SINGLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            produced_reg  <= produced_next;
            lit_pend_reg  <= lit_pend_next;
            pair_high_reg <= pair_high_next;
            pair_pend_reg <= pair_pend_next;
            sticky_reg    <= sticky_next;
            limit_reg     <= limit_next;
            cnt_reg       <= cnt_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        dist_reg      <= dist_next;
        emit_byte_reg <= emit_byte_next;
        out_data_reg  <= out_data_next;
    end

    assign in_stall  = (state_reg != lz77bp_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_done_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.record_done) |-> out_data_reg.run_last)
        else $error("record close result is not the last result of its byte");

    a_empty_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.byte_valid) |-> out_data_reg.record_done)
        else $error("result without data outside a record close");

    a_copy_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lz77bp_pkg::S_COPY_RD) |=> (state_reg == lz77bp_pkg::S_EMIT))
        else $error("history read not followed by emit step");

    a_emit_needs_clean_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lz77bp_pkg::S_EMIT) |-> (sticky_reg == lz77bp_pkg::ST_OK))
        else $error("data emitted after a record error");
`endif

endmodule

FILE: tb/sv/lz77_byte_pair_decompressor_top_tb.sv
// Self-checking testbench for the byte-pair LZ77 decompressor top level.
// Depends on lz77bp_pkg and lz77_byte_pair_decompressor_top; needs no files.
// A directed table runs first, then random records under several output limit values.
module lz77_byte_pair_decompressor_top_tb;
    import lz77bp_pkg::*;

    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 220;
    localparam int PHASES         = 4;

    typedef struct packed {
        logic        is_cfg;
        logic [12:0] limit;
        logic [7:0]  in_byte;
        logic        rec_last;
        logic        typed;
        out_item_t   res;
    } row_t;

    localparam out_item_t NO_RES = '0;

    // Typed results hold: out_byte, byte_valid, run_last, record_done, status, length.
    localparam row_t DIR_ROWS [25] = '{
        '{1'b0, 13'd0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, ST_OK, 13'd1}},
        '{1'b0, 13'd0, 8'h7f, 1'b0, 1'b1, '{8'h7f, 1'b1, 1'b1, 1'b0, ST_OK, 13'd1}},
        '{1'b0, 13'd0, 8'hff, 1'b0, 1'b0, NO_RES},
        '{1'b0, 13'd0, 8'h03, 1'b0, 1'b0, NO_RES},
        '{1'b0, 13'd0, 8'h80, 1'b0, 1'b0, NO_RES},
        '{1'b0, 13'd0, 8'h01, 1'b0, 1'b0, NO_RES},
        '{1'b0, 13'd0, 8'hfe, 1'b0, 1'b0, NO_RES},
        '{1'b0, 13'd0, 8'h80, 1'b0, 1'b0, NO_RES},
        '{1'b0, 13'd0, 8'h0f, 1'b0, 1'b0, NO_RES},
        '{1'b0, 13'd0, 8'hbf, 1'b0, 1'b0, NO_RES},
        '{1'b0, 13'd0, 8'hff, 1'b0, 1'b0, NO_RES},
        '{1'b0, 13'd0, 8'h41, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ST_BAD_DIST, 13'd16}},
        '{1'b0, 13'd0, 8'h80, 1'b0, 1'b0, NO_RES},
        '{1'b0, 13'd0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ST_BAD_DIST, 13'd0}},
        '{1'b0, 13'd0, 8'h05, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ST_TRUNC, 13'd0}},
        '{1'b0, 13'd0, 8'h90, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ST_TRUNC, 13'd0}},
        '{1'b1, 13'd1, 8'h00, 1'b0, 1'b0, NO_RES},
        '{1'b0, 13'd0, 8'hc1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ST_OVERFLOW, 13'd0}},
        '{1'b0, 13'd0, 8'h41, 1'b0, 1'b1, '{8'h41, 1'b1, 1'b1, 1'b0, ST_OK, 13'd1}},
        '{1'b0, 13'd0, 8'h42, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ST_OVERFLOW, 13'd1}},
        '{1'b0, 13'd0, 8'h02, 1'b0, 1'b0, NO_RES},
        '{1'b0, 13'd0, 8'h55, 1'b0, 1'b0, NO_RES},
        '{1'b0, 13'd0, 8'h66, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ST_OVERFLOW, 13'd0}},
        '{1'b1, 13'd8191, 8'h00, 1'b0, 1'b0, NO_RES},
        '{1'b0, 13'd0, 8'h09, 1'b1, 1'b0, NO_RES}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_we;
    logic [12:0] cfg_wdata;

    // Decoder state mirrored by the testbench.
    logic [7:0]  hist_mem [HIST_DEPTH];
    int unsigned produced_cnt;
    int unsigned lit_left;
    logic [5:0]  pair_hi;
    logic        pair_open;
    logic [1:0]  err_st;
    logic [12:0] limit_reg;

    out_item_t   step_out [$];
    out_item_t   decoded_q [$];
    in_item_t    rec_q [$];

    int          mismatch_cnt = 0;
    bit          gaps_on;
    int          burst_left;
    bit          long_hold_req = 1'b0;

    lz77_byte_pair_decompressor_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void put_result(input logic [7:0] b, input logic v);
        if (step_out.size() < 10)
            step_out.push_back('{b, v, 1'b0, 1'b0, err_st, produced_cnt[12:0]});
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        if (err_st != ST_OK)
            return;
        hist_mem[produced_cnt % HIST_DEPTH] = b;
        produced_cnt = (produced_cnt + 1) & 32'h1fff;
        put_result(b, 1'b1);
    endfunction

    function automatic bit has_room(input int unsigned need);
        if (err_st != ST_OK)
            return 1'b0;
        if (produced_cnt + need > limit_reg)
        begin
            err_st = ST_OVERFLOW;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Decodes one compressed byte into step_out.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        logic [13:0] pair_word;
        int unsigned back_dist;
        int unsigned run;
        int unsigned src;
        out_item_t   tail;
        step_out.delete();
        if (lit_left != 0)
        begin
            lit_left--;
            emit_byte(b);
        end
        else if (pair_open)
        begin
            pair_word = {pair_hi, b};
            back_dist = pair_word[13:3];
            run = pair_word[2:0] + 3;
            pair_open = 1'b0;
            pair_hi = '0;
            if (err_st == ST_OK)
            begin
                if (back_dist == 0 || back_dist > produced_cnt)
                    err_st = ST_BAD_DIST;
                else if (has_room(run))
                    for (int i = 0; i < run; i++)
                    begin
                        src = (produced_cnt - back_dist) % HIST_DEPTH;
                        emit_byte(hist_mem[src]);
                    end
            end
        end
        else if (b != 0 && b <= LIT_MAX)
        begin
            void'(has_room(b));
            lit_left = b;
        end
        else if (b < PAIR_BASE)
        begin
            if (has_room(1))
                emit_byte(b);
        end
        else if (b >= SPACE_BASE)
        begin
            if (has_room(2))
            begin
                emit_byte(SPACE_CHAR);
                emit_byte(b ^ XOR_MASK);
            end
        end
        else
        begin
            pair_hi = b[5:0];
            pair_open = 1'b1;
        end

        if (last)
        begin
            if ((lit_left != 0 || pair_open) && err_st == ST_OK)
                err_st = ST_TRUNC;
            if (step_out.size() == 0)
                put_result(8'h00, 1'b0);
            tail = step_out.pop_back();
            tail.record_done = 1'b1;
            tail.status = err_st;
            tail.record_length = produced_cnt[12:0];
            step_out.push_back(tail);
            produced_cnt = 0;
            lit_left = 0;
            pair_hi = '0;
            pair_open = 1'b0;
            err_st = ST_OK;
        end

        if (step_out.size() > 0)
        begin
            tail = step_out.pop_back();
            tail.run_last = 1'b1;
            step_out.push_back(tail);
        end
    endfunction

    function automatic void check_field(input string name, input logic [12:0] want,
                                        input logic [12:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                $error("result transfer with nothing outstanding: 0x%0h", out_data);
                mismatch_cnt++;
            end
            else
            begin
                want = decoded_q.pop_front();
                check_field("out_byte", want.out_byte, out_data.out_byte);
                check_field("byte_valid", want.byte_valid, out_data.byte_valid);
                check_field("run_last", want.run_last, out_data.run_last);
                check_field("record_done", want.record_done, out_data.record_done);
                check_field("status", want.status, out_data.status);
                check_field("record_length", want.record_length, out_data.record_length);
            end
        end
    end

    // Receiver: a changing stall pattern, plus a long hold-off on request.
    initial
    begin : receiver
        int hold_left;
        int cyc;
        int mode;
        hold_left = 0;
        cyc = 0;
        mode = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 50 == 0)
                mode = $urandom_range(0, 3);
            if (long_hold_req)
            begin
                hold_left = HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 9) < 3);
                    2: out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= (cyc % 5 < 2);
                endcase
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // Offers one byte, waits for its transfer, then books the decoded results.
    task automatic push_byte(input in_item_t item, input bit typed, input out_item_t res);
        int gap;
        @(negedge clk);
        in_data <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(item.in_byte, item.rec_last);
        if (typed)
            decoded_q.push_back(res);
        else
            foreach (step_out[i])
                decoded_q.push_back(step_out[i]);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 16);
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // A command byte can still be in flight after the last result, hence the settle time.
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [12:0] value);
        quiesce();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        limit_reg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void add_byte(input logic [7:0] b);
        rec_q.push_back('{b, 1'b0});
    endfunction

    // Mostly well-formed records; a few carry a bad distance, a cut-off end or noise.
    function automatic void build_record(input bit faulty);
        int unsigned gen_len;
        int unsigned n_cmds;
        int unsigned kind;
        int unsigned n;
        int unsigned back_dist;
        logic [13:0] word;
        in_item_t    tail;
        rec_q.delete();
        gen_len = 0;
        n_cmds = $urandom_range(1, 14);
        for (int c = 0; c < n_cmds; c++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                add_byte(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(9, 127)));
                gen_len += 1;
            end
            else if (kind < 35)
            begin
                add_byte(8'($urandom_range(SPACE_BASE, 255)));
                gen_len += 2;
            end
            else if (kind < 60)
            begin
                n = $urandom_range(1, LIT_MAX);
                add_byte(8'(n));
                for (int i = 0; i < n; i++)
                    add_byte(8'($urandom_range(0, 255)));
                gen_len += n;
            end
            else if (gen_len > 0)
            begin
                back_dist = $urandom_range(1, (gen_len > 2047) ? 2047 : gen_len);
                word = {back_dist[10:0], 3'($urandom_range(0, 7))};
                add_byte(PAIR_BASE | {2'b00, word[13:8]});
                add_byte(word[7:0]);
                gen_len += word[2:0] + 3;
            end
            else
            begin
                add_byte(8'($urandom_range(9, 127)));
                gen_len += 1;
            end
        end
        if (faulty)
            case ($urandom_range(0, 2))
                0:
                begin
                    back_dist = ($urandom_range(0, 3) == 0) ? 0
                                                            : gen_len + $urandom_range(1, 20);
                    if (back_dist > 2047)
                        back_dist = 2047;
                    word = {back_dist[10:0], 3'($urandom_range(0, 7))};
                    add_byte(PAIR_BASE | {2'b00, word[13:8]});
                    add_byte(word[7:0]);
                    add_byte(8'($urandom_range(9, 127)));
                end
                1:
                    add_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, LIT_MAX))
                                                         : 8'($urandom_range(128, 191)));
                default:
                    repeat ($urandom_range(3, 10)) add_byte(8'($urandom_range(0, 255)));
            endcase
        tail = rec_q.pop_back();
        tail.rec_last = 1'b1;
        rec_q.push_back(tail);
    endfunction

    initial
    begin : stimulus
        int unsigned rand_items;
        bit          held;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        foreach (hist_mem[i])
            hist_mem[i] = '0;
        produced_cnt = 0;
        lit_left = 0;
        pair_hi = '0;
        pair_open = 1'b0;
        err_st = ST_OK;
        limit_reg = LIMIT_RESET;
        gaps_on = 1'b1;
        burst_left = 0;
        rand_items = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIR_ROWS[r])
        begin
            if (DIR_ROWS[r].is_cfg)
                write_limit(DIR_ROWS[r].limit);
            else
                push_byte('{DIR_ROWS[r].in_byte, DIR_ROWS[r].rec_last},
                          DIR_ROWS[r].typed, DIR_ROWS[r].res);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: write_limit(13'($urandom_range(16, 48)));
                1: write_limit(13'd8191);
                2: write_limit(LIMIT_RESET);
                default: write_limit(13'($urandom_range(1, 8191)));
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            held = 1'b0;
            while (rand_items < RANDOM_ITEMS * (phase + 1) / PHASES)
            begin
                build_record($urandom_range(0, 9) < 2);
                // Stall the output for a long stretch while input keeps coming.
                if (phase % 2 == 1 && !held)
                begin
                    long_hold_req = 1'b1;
                    held = 1'b1;
                end
                foreach (rec_q[k])
                    push_byte(rec_q[k], 1'b0, NO_RES);
                rand_items += rec_q.size();
            end
        end

        quiesce();
        if (mismatch_cnt == 0 && decoded_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
